// ===== rtl/rcs_pkg.sv =====
package rcs_pkg;

    // Defaults for the top-level parameters
    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int STEM_COUNT_DEF    = 8;
    localparam int SETTING_WIDTH_DEF = 32;

    // Fixed field widths of the request and result channels
    localparam int FUNC_W         = 3;
    localparam int STEM_IDX_W     = 8;
    localparam int SETTING_PORT_W = 32;
    localparam int MODE_W         = 3;
    localparam int MASK_W         = 8;
    localparam int CNT_W          = 32;
    localparam int NUM_CNT        = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_START    = 3'd0,
        FUNC_STOP     = 3'd1,
        FUNC_ARM      = 3'd2,
        FUNC_DISARM   = 3'd3,
        FUNC_BOUNDARY = 3'd4
    } func_t;

    // Command kind as stored in the ring
    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_STOP   = 2'd1,
        KIND_ARM    = 2'd2,
        KIND_DISARM = 2'd3
    } kind_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE          = 3'd0,
        MODE_START_PENDING = 3'd1,
        MODE_RECORDING     = 3'd2,
        MODE_STOP_PENDING  = 3'd3,
        MODE_FINALIZING    = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        CNT_START       = 3'd0,
        CNT_STOP        = 3'd1,
        CNT_ARM         = 3'd2,
        CNT_DISARM      = 3'd3,
        CNT_REF_SETTING = 3'd4,
        CNT_REF_MODE    = 3'd5,
        CNT_BOUNDARY    = 3'd6,
        CNT_TRANSITION  = 3'd7
    } cnt_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DRAIN  = 3'b010,
        ST_REPORT = 3'b100
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic drain;
        logic report;
    } dp_cmd_t;

    typedef struct packed {
        logic boundary;
        logic queue_empty;
    } dp_status_t;

    typedef struct packed {
        logic              accepted;
        logic [MODE_W-1:0] mode;
        logic [MASK_W-1:0] armed_mask;
        logic [CNT_W-1:0]  start_count;
        logic [CNT_W-1:0]  stop_count;
        logic [CNT_W-1:0]  arm_count;
        logic [CNT_W-1:0]  disarm_count;
        logic [CNT_W-1:0]  refused_setting_count;
        logic [CNT_W-1:0]  refused_mode_count;
        logic [CNT_W-1:0]  boundary_count;
        logic [CNT_W-1:0]  transition_total;
    } result_t;

endpackage

// ===== rtl/rcs_if.sv =====
interface rcs_req_if;
    import rcs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic [STEM_IDX_W-1:0]     stem_index;
    logic [SETTING_PORT_W-1:0] stem_setting;

    modport source (output valid, output func, output stem_index, output stem_setting,
                    input ready);
    modport sink (input valid, input func, input stem_index, input stem_setting,
                  output ready);
endinterface

interface rcs_res_if;
    import rcs_pkg::*;

    logic              valid;
    logic              ready;
    logic              accepted;
    logic [MODE_W-1:0] mode;
    logic [MASK_W-1:0] armed_mask;
    logic [CNT_W-1:0]  start_count;
    logic [CNT_W-1:0]  stop_count;
    logic [CNT_W-1:0]  arm_count;
    logic [CNT_W-1:0]  disarm_count;
    logic [CNT_W-1:0]  refused_setting_count;
    logic [CNT_W-1:0]  refused_mode_count;
    logic [CNT_W-1:0]  boundary_count;
    logic [CNT_W-1:0]  transition_total;

    modport source (output valid, output accepted, output mode, output armed_mask,
                    output start_count, output stop_count, output arm_count,
                    output disarm_count, output refused_setting_count,
                    output refused_mode_count, output boundary_count,
                    output transition_total, input ready);
    modport sink (input valid, input accepted, input mode, input armed_mask,
                  input start_count, input stop_count, input arm_count,
                  input disarm_count, input refused_setting_count,
                  input refused_mode_count, input boundary_count,
                  input transition_total, output ready);
endinterface

// ===== rtl/rcs_ctrl.sv =====
module rcs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rcs_pkg::dp_status_t  status,
    output rcs_pkg::dp_cmd_t     cmd
);
    import rcs_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = out_free;
                cmd.take = in_valid && out_free;
                if (cmd.take)
                begin
                    state_next = status.boundary ? ST_DRAIN : ST_REPORT;
                end
            end
            ST_DRAIN:
            begin
                // Step one command, or advance the mode once the ring is empty
                cmd.drain = 1'b1;
                if (status.queue_empty)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.report)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/rcs_datapath.sv =====
module rcs_datapath #(
    parameter int QUEUE_DEPTH   = rcs_pkg::QUEUE_DEPTH_DEF,
    parameter int STEM_COUNT    = rcs_pkg::STEM_COUNT_DEF,
    parameter int SETTING_WIDTH = rcs_pkg::SETTING_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rcs_pkg::dp_cmd_t                   cmd,
    output rcs_pkg::dp_status_t                status,
    input  logic [rcs_pkg::FUNC_W-1:0]         func,
    input  logic [rcs_pkg::STEM_IDX_W-1:0]     stem_index,
    input  logic [rcs_pkg::SETTING_PORT_W-1:0] stem_setting,
    output rcs_pkg::result_t                   result
);
    import rcs_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int STEM_W = (STEM_COUNT > 1) ? $clog2(STEM_COUNT) : 1;
    localparam int SV_W   = STEM_IDX_W + 1;

    typedef struct packed {
        kind_t                    kind;
        logic [STEM_W-1:0]        stem;
        logic [SETTING_WIDTH-1:0] setting;
    } entry_t;

    entry_t                   ring_mem [QUEUE_DEPTH];
    entry_t                   ring_rdata_reg;
    entry_t                   ring_wdata;
    logic                     ring_we;

    logic [PTR_W-1:0]         wp_reg, wp_next, rp_reg, rp_next, wp_inc;
    mode_t                    mode_reg, mode_next;
    logic [STEM_COUNT-1:0]    armed_reg, armed_next;
    logic [SETTING_WIDTH-1:0] settings_reg  [STEM_COUNT];
    logic [SETTING_WIDTH-1:0] settings_next [STEM_COUNT];
    logic [CNT_W-1:0]         cnt_reg [NUM_CNT];
    logic                     bump_en;
    cnt_idx_t                 bump_idx;
    logic                     ok_reg, ok_next;
    result_t                  result_reg;

    logic                     full, empty, stem_valid;
    logic [SETTING_WIDTH-1:0] setting_kept;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign wp_inc       = ptr_inc(wp_reg);
    assign full         = (wp_inc == rp_reg);
    assign empty        = (wp_reg == rp_reg);
    assign stem_valid   = ({1'b0, stem_index} < SV_W'(STEM_COUNT));
    assign setting_kept = SETTING_WIDTH'(stem_setting);

    assign status.boundary    = (func == FUNC_BOUNDARY);
    assign status.queue_empty = empty;

    always_comb
    begin
        wp_next            = wp_reg;
        rp_next            = rp_reg;
        mode_next          = mode_reg;
        armed_next         = armed_reg;
        settings_next      = settings_reg;
        ok_next            = ok_reg;
        bump_en            = 1'b0;
        bump_idx           = CNT_START;
        ring_we            = 1'b0;
        ring_wdata.kind    = kind_t'(func[1:0]);
        ring_wdata.stem    = STEM_W'(stem_index);
        ring_wdata.setting = (func == FUNC_ARM) ? setting_kept : '0;

        if (cmd.take)
        begin
            ok_next = 1'b0;
            unique case (func)
                FUNC_START, FUNC_STOP:
                begin
                    if (!full)
                    begin
                        ring_we  = 1'b1;
                        wp_next  = wp_inc;
                        bump_en  = 1'b1;
                        bump_idx = (func == FUNC_START) ? CNT_START : CNT_STOP;
                        ok_next  = 1'b1;
                    end
                end
                FUNC_ARM, FUNC_DISARM:
                begin
                    if (stem_valid)
                    begin
                        if (mode_reg != MODE_IDLE)
                        begin
                            bump_en  = 1'b1;
                            bump_idx = CNT_REF_SETTING;
                        end
                        else if (!full)
                        begin
                            ring_we  = 1'b1;
                            wp_next  = wp_inc;
                            bump_en  = 1'b1;
                            bump_idx = (func == FUNC_ARM) ? CNT_ARM : CNT_DISARM;
                            ok_next  = 1'b1;
                        end
                    end
                end
                FUNC_BOUNDARY:
                begin
                    bump_en  = 1'b1;
                    bump_idx = CNT_BOUNDARY;
                    ok_next  = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.drain)
        begin
            if (!empty)
            begin
                rp_next = ptr_inc(rp_reg);
                bump_en = 1'b1;
                unique case (ring_rdata_reg.kind)
                    KIND_START:
                    begin
                        if (mode_reg == MODE_IDLE)
                        begin
                            mode_next = MODE_START_PENDING;
                            bump_idx  = CNT_TRANSITION;
                        end
                        else
                        begin
                            bump_idx = CNT_REF_MODE;
                        end
                    end
                    KIND_STOP:
                    begin
                        if (mode_reg == MODE_RECORDING)
                        begin
                            mode_next = MODE_STOP_PENDING;
                            bump_idx  = CNT_TRANSITION;
                        end
                        else
                        begin
                            bump_idx = CNT_REF_MODE;
                        end
                    end
                    KIND_ARM:
                    begin
                        if (mode_reg == MODE_IDLE)
                        begin
                            bump_en = 1'b0;
                            settings_next[ring_rdata_reg.stem] = ring_rdata_reg.setting;
                            armed_next[ring_rdata_reg.stem]    = 1'b1;
                        end
                        else
                        begin
                            bump_idx = CNT_REF_SETTING;
                        end
                    end
                    KIND_DISARM:
                    begin
                        if (mode_reg == MODE_IDLE)
                        begin
                            bump_en = 1'b0;
                            settings_next[ring_rdata_reg.stem] = '0;
                            armed_next[ring_rdata_reg.stem]    = 1'b0;
                        end
                        else
                        begin
                            bump_idx = CNT_REF_SETTING;
                        end
                    end
                endcase
            end
            else
            begin
                // Ring empty: advance a pending or finalizing mode one step
                bump_idx = CNT_TRANSITION;
                priority if (mode_reg == MODE_START_PENDING)
                begin
                    mode_next = MODE_RECORDING;
                    bump_en   = 1'b1;
                end
                else if (mode_reg == MODE_STOP_PENDING)
                begin
                    mode_next = MODE_FINALIZING;
                    bump_en   = 1'b1;
                end
                else if (mode_reg == MODE_FINALIZING)
                begin
                    mode_next = MODE_IDLE;
                    bump_en   = 1'b1;
                end
                else
                begin
                end
            end
        end
    end

    // Ring memory: read port follows the next read pointer every cycle
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wp_reg] <= ring_wdata;
        end
        ring_rdata_reg <= ring_mem[rp_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            rp_reg       <= '0;
            mode_reg     <= MODE_IDLE;
            armed_reg    <= '0;
            settings_reg <= '{default: '0};
            cnt_reg      <= '{default: '0};
        end
        else
        begin
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            mode_reg     <= mode_next;
            armed_reg    <= armed_next;
            settings_reg <= settings_next;
            if (bump_en)
            begin
                cnt_reg[bump_idx] <= cnt_reg[bump_idx] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next;
        if (cmd.report)
        begin
            result_reg.accepted              <= ok_reg;
            result_reg.mode                  <= mode_reg;
            result_reg.armed_mask            <= MASK_W'(armed_reg);
            result_reg.start_count           <= cnt_reg[CNT_START];
            result_reg.stop_count            <= cnt_reg[CNT_STOP];
            result_reg.arm_count             <= cnt_reg[CNT_ARM];
            result_reg.disarm_count          <= cnt_reg[CNT_DISARM];
            result_reg.refused_setting_count <= cnt_reg[CNT_REF_SETTING];
            result_reg.refused_mode_count    <= cnt_reg[CNT_REF_MODE];
            result_reg.boundary_count        <= cnt_reg[CNT_BOUNDARY];
            result_reg.transition_total      <= cnt_reg[CNT_TRANSITION];
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/recorder_command_sequencer_top.sv =====
// Channel | Modport | Transfer carries
// --------+---------+------------------------------------------------------------
// req     | sink    | func, stem_index, stem_setting
// res     | source  | accepted, mode, armed_mask and the eight event counters
//
// A request's result is loaded into the output register in the report state that
// follows its transfer; the next request can transfer once the controller is idle.
// A block boundary goes through the drain state first: the commands queued (up to
// QUEUE_DEPTH - 1) are walked one command per cycle through the ring memory's
// registered read port, then a last drain step with the ring empty advances the mode.
// One item is in work at a time; req.ready is high while the controller is idle and
// the output register is empty or its result transfers in that cycle.
// rst_n is asynchronous, active low; it empties the ring and clears mode and counters.
module recorder_command_sequencer_top #(
    parameter int QUEUE_DEPTH   = rcs_pkg::QUEUE_DEPTH_DEF,
    parameter int STEM_COUNT    = rcs_pkg::STEM_COUNT_DEF,
    parameter int SETTING_WIDTH = rcs_pkg::SETTING_WIDTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    rcs_req_if.sink   req,
    rcs_res_if.source res
);
    import rcs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    result_t    result;

    // Sequencer: accept, drain/advance, report
    rcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Ring, recorder mode, stem state, counters and the output register
    rcs_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .STEM_COUNT    (STEM_COUNT),
        .SETTING_WIDTH (SETTING_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .func         (req.func),
        .stem_index   (req.stem_index),
        .stem_setting (req.stem_setting),
        .result       (result)
    );

    // Drive the result payload; it holds while a transfer stalls
    assign res.accepted              = result.accepted;
    assign res.mode                  = result.mode;
    assign res.armed_mask            = result.armed_mask;
    assign res.start_count           = result.start_count;
    assign res.stop_count            = result.stop_count;
    assign res.arm_count             = result.arm_count;
    assign res.disarm_count          = result.disarm_count;
    assign res.refused_setting_count = result.refused_setting_count;
    assign res.refused_mode_count    = result.refused_mode_count;
    assign res.boundary_count        = result.boundary_count;
    assign res.transition_total      = result.transition_total;

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcs_pkg::*;

    // Function codes the block does not decode; they must come back refused
    // with every counter untouched.
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    localparam int RING_ROOM    = QUEUE_DEPTH_DEF - 1;   // one ring slot stays empty
    localparam int RAND_ITEMS   = 1125;
    localparam int SCRIPT_LEN   = 25;
    localparam int SETTLE_CYC   = QUEUE_DEPTH_DEF + 8;   // longest boundary plus margin
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LINES = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    rcs_req_if req_ch ();
    rcs_res_if res_ch ();

    recorder_command_sequencer_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // ------------------------------------------------------------------
    // Recorder model: command ring, mode, armed stems and event counters,
    // updated once per request transfer.
    // ------------------------------------------------------------------
    typedef struct {
        kind_t                     kind;
        logic [STEM_IDX_W-1:0]     stem;
        logic [SETTING_PORT_W-1:0] word;
    } cmd_rec_t;

    // One expected status, plus the few fields typed into the directed
    // table for rows whose outcome is obvious on sight.
    typedef struct {
        result_t           r;
        bit                pinned;
        logic              acc;
        mode_t             md;
        logic [MASK_W-1:0] mask;
    } due_t;

    typedef struct {
        logic [FUNC_W-1:0]         f;
        logic [STEM_IDX_W-1:0]     stem;
        logic [SETTING_PORT_W-1:0] word;
        bit                        pinned;
        logic                      acc;
        mode_t                     md;
        logic [MASK_W-1:0]         mask;
    } script_row_t;

    cmd_rec_t                  cmd_fifo[$];
    mode_t                     rec_mode = MODE_IDLE;
    logic [MASK_W-1:0]         armed = '0;
    logic [SETTING_PORT_W-1:0] stem_word [STEM_COUNT_DEF] = '{default: '0};
    logic [CNT_W-1:0]          ev_cnt [NUM_CNT] = '{default: '0};

    due_t status_due[$];
    int   mismatches = 0;
    int   burst_left = 0;
    int   cycles = 0;

    function automatic void bump(cnt_idx_t which);
        ev_cnt[which] = ev_cnt[which] + 1'b1;
    endfunction

    // Count a mode change only when the mode really moves.
    function automatic void move_to(mode_t next_mode);
        if (rec_mode != next_mode) begin
            rec_mode = next_mode;
            bump(CNT_TRANSITION);
        end
    endfunction

    // Refuse when the ring already holds its maximum of commands.
    function automatic bit queue_cmd(kind_t kind, logic [STEM_IDX_W-1:0] stem,
                                     logic [SETTING_PORT_W-1:0] word);
        cmd_rec_t c;
        if (cmd_fifo.size() >= RING_ROOM)
            return 1'b0;
        c.kind = kind;
        c.stem = stem;
        c.word = word;
        cmd_fifo.push_back(c);
        return 1'b1;
    endfunction

    // Drain every queued command in order, then advance a pending or finalizing mode.
    function automatic void run_block();
        cmd_rec_t c;
        while (cmd_fifo.size() > 0) begin
            c = cmd_fifo.pop_front();
            case (c.kind)
                KIND_START:
                    if (rec_mode == MODE_IDLE) move_to(MODE_START_PENDING);
                    else bump(CNT_REF_MODE);
                KIND_STOP:
                    if (rec_mode == MODE_RECORDING) move_to(MODE_STOP_PENDING);
                    else bump(CNT_REF_MODE);
                KIND_ARM:
                    if (rec_mode == MODE_IDLE && c.stem < STEM_COUNT_DEF) begin
                        stem_word[c.stem] = c.word;
                        armed[c.stem] = 1'b1;
                    end else begin
                        bump(CNT_REF_SETTING);
                    end
                KIND_DISARM:
                    if (rec_mode == MODE_IDLE && c.stem < STEM_COUNT_DEF) begin
                        stem_word[c.stem] = '0;
                        armed[c.stem] = 1'b0;
                    end else begin
                        bump(CNT_REF_SETTING);
                    end
                default: ;
            endcase
        end
        if (rec_mode == MODE_START_PENDING) move_to(MODE_RECORDING);
        else if (rec_mode == MODE_STOP_PENDING) move_to(MODE_FINALIZING);
        else if (rec_mode == MODE_FINALIZING) move_to(MODE_IDLE);
    endfunction

    // Apply one request and return the status the block must report for it.
    function automatic result_t recorder_after(logic [FUNC_W-1:0] f,
                                               logic [STEM_IDX_W-1:0] stem,
                                               logic [SETTING_PORT_W-1:0] word);
        result_t r;
        logic    ok;
        ok = 1'b0;
        case (f)
            FUNC_START:
                if (queue_cmd(KIND_START, '0, '0)) begin
                    bump(CNT_START);
                    ok = 1'b1;
                end
            FUNC_STOP:
                if (queue_cmd(KIND_STOP, '0, '0)) begin
                    bump(CNT_STOP);
                    ok = 1'b1;
                end
            FUNC_ARM:
                // stem validity wins over the mode check: no count at all
                if (stem < STEM_COUNT_DEF) begin
                    if (rec_mode != MODE_IDLE) begin
                        bump(CNT_REF_SETTING);
                    end else if (queue_cmd(KIND_ARM, stem, word)) begin
                        bump(CNT_ARM);
                        ok = 1'b1;
                    end
                end
            FUNC_DISARM:
                if (stem < STEM_COUNT_DEF) begin
                    if (rec_mode != MODE_IDLE) begin
                        bump(CNT_REF_SETTING);
                    end else if (queue_cmd(KIND_DISARM, stem, '0)) begin
                        bump(CNT_DISARM);
                        ok = 1'b1;
                    end
                end
            FUNC_BOUNDARY: begin
                bump(CNT_BOUNDARY);
                run_block();
                ok = 1'b1;
            end
            default: ;
        endcase
        r.accepted              = ok;
        r.mode                  = rec_mode;
        r.armed_mask            = armed;
        r.start_count           = ev_cnt[CNT_START];
        r.stop_count            = ev_cnt[CNT_STOP];
        r.arm_count             = ev_cnt[CNT_ARM];
        r.disarm_count          = ev_cnt[CNT_DISARM];
        r.refused_setting_count = ev_cnt[CNT_REF_SETTING];
        r.refused_mode_count    = ev_cnt[CNT_REF_MODE];
        r.boundary_count        = ev_cnt[CNT_BOUNDARY];
        r.transition_total      = ev_cnt[CNT_TRANSITION];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and status comparison
    // ------------------------------------------------------------------
    task automatic flag(string field, longint unsigned got, longint unsigned want);
        mismatches++;
        if (mismatches <= REPORT_LINES)
            $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", field, got, want, $realtime);
    endtask

    task automatic check_status(result_t got, due_t e);
        if (got.accepted !== e.r.accepted)
            flag("accepted", got.accepted, e.r.accepted);
        if (got.mode !== e.r.mode)
            flag("mode", got.mode, e.r.mode);
        if (got.armed_mask !== e.r.armed_mask)
            flag("armed_mask", got.armed_mask, e.r.armed_mask);
        if (got.start_count !== e.r.start_count)
            flag("start_count", got.start_count, e.r.start_count);
        if (got.stop_count !== e.r.stop_count)
            flag("stop_count", got.stop_count, e.r.stop_count);
        if (got.arm_count !== e.r.arm_count)
            flag("arm_count", got.arm_count, e.r.arm_count);
        if (got.disarm_count !== e.r.disarm_count)
            flag("disarm_count", got.disarm_count, e.r.disarm_count);
        if (got.refused_setting_count !== e.r.refused_setting_count)
            flag("refused_setting_count", got.refused_setting_count,
                 e.r.refused_setting_count);
        if (got.refused_mode_count !== e.r.refused_mode_count)
            flag("refused_mode_count", got.refused_mode_count, e.r.refused_mode_count);
        if (got.boundary_count !== e.r.boundary_count)
            flag("boundary_count", got.boundary_count, e.r.boundary_count);
        if (got.transition_total !== e.r.transition_total)
            flag("transition_total", got.transition_total, e.r.transition_total);
        // Table rows also carry hand-written values
        if (e.pinned) begin
            if (got.accepted !== e.acc)
                flag("accepted (table)", got.accepted, e.acc);
            if (got.mode !== e.md)
                flag("mode (table)", got.mode, e.md);
            if (got.armed_mask !== e.mask)
                flag("armed_mask (table)", got.armed_mask, e.mask);
        end
    endtask

    // ------------------------------------------------------------------
    // Request side: offer one item, hold it until the transfer, then
    // book the expected status. Between bursts drop valid for a gap.
    // ------------------------------------------------------------------
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic offer(input logic [FUNC_W-1:0] f, input logic [STEM_IDX_W-1:0] stem,
                         input logic [SETTING_PORT_W-1:0] word, input due_t pin);
        req_ch.valid        <= 1'b1;
        req_ch.func         <= f;
        req_ch.stem_index   <= stem;
        req_ch.stem_setting <= word;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        // The transfer happened at this edge
        pin.r = recorder_after(f, stem, word);
        status_due.push_back(pin);
        pace();
    endtask

    // Directed table. Pinned rows state accepted, mode and mask outright;
    // the rest lean on the model alone.
    script_row_t script [SCRIPT_LEN] = '{
        // unknown function codes after reset
        '{FUNC_SPARE_LO, 8'd0,   32'h0000_0000, 1'b1, 1'b0, MODE_IDLE,      8'h00},
        '{FUNC_SPARE_HI, 8'd255, 32'hFFFF_FFFF, 1'b1, 1'b0, MODE_IDLE,      8'h00},
        // stem out of range: refused with no count
        '{FUNC_ARM,      8'd8,   32'h0000_005A, 1'b1, 1'b0, MODE_IDLE,      8'h00},
        '{FUNC_DISARM,   8'd255, 32'hFFFF_FFFF, 1'b1, 1'b0, MODE_IDLE,      8'h00},
        // arm both ends of the stem range, with extreme settings words
        '{FUNC_ARM,      8'd0,   32'h0000_0000, 1'b1, 1'b1, MODE_IDLE,      8'h00},
        '{FUNC_ARM,      8'd7,   32'hFFFF_FFFF, 1'b1, 1'b1, MODE_IDLE,      8'h00},
        '{FUNC_BOUNDARY, 8'd0,   32'h0000_0000, 1'b1, 1'b1, MODE_IDLE,      8'h81},
        // disarm plus start in one block
        '{FUNC_DISARM,   8'd0,   32'h1234_5678, 1'b1, 1'b1, MODE_IDLE,      8'h81},
        '{FUNC_START,    8'd0,   32'h0000_0000, 1'b1, 1'b1, MODE_IDLE,      8'h81},
        '{FUNC_BOUNDARY, 8'd255, 32'hFFFF_FFFF, 1'b1, 1'b1, MODE_RECORDING, 8'h80},
        // arm while recording: refused and counted; bad stem still uncounted
        '{FUNC_ARM,      8'd3,   32'h0000_1234, 1'b1, 1'b0, MODE_RECORDING, 8'h80},
        '{FUNC_ARM,      8'd9,   32'h0000_1234, 1'b1, 1'b0, MODE_RECORDING, 8'h80},
        // start refused at drain, stop takes effect
        '{FUNC_START,    8'd0,   32'h0000_0000, 1'b0, 1'b0, MODE_IDLE,      8'h00},
        '{FUNC_STOP,     8'd0,   32'h0000_0000, 1'b0, 1'b0, MODE_IDLE,      8'h00},
        '{FUNC_BOUNDARY, 8'd0,   32'h0000_0000, 1'b1, 1'b1, MODE_FINALIZING, 8'h80},
        // stop refused while finalizing, then back to idle
        '{FUNC_STOP,     8'd0,   32'h0000_0000, 1'b0, 1'b0, MODE_IDLE,      8'h00},
        '{FUNC_BOUNDARY, 8'd0,   32'h0000_0000, 1'b1, 1'b1, MODE_IDLE,      8'h80},
        // arm queued behind a start: refused at drain time
        '{FUNC_START,    8'd0,   32'h0000_0000, 1'b0, 1'b0, MODE_IDLE,      8'h00},
        '{FUNC_ARM,      8'd2,   32'hA5A5_A5A5, 1'b0, 1'b0, MODE_IDLE,      8'h00},
        '{FUNC_BOUNDARY, 8'd0,   32'h0000_0000, 1'b1, 1'b1, MODE_RECORDING, 8'h80},
        '{FUNC_STOP,     8'd0,   32'h0000_0000, 1'b0, 1'b0, MODE_IDLE,      8'h00},
        '{FUNC_BOUNDARY, 8'd0,   32'h0000_0000, 1'b1, 1'b1, MODE_FINALIZING, 8'h80},
        '{FUNC_BOUNDARY, 8'd0,   32'h0000_0000, 1'b1, 1'b1, MODE_IDLE,      8'h80},
        '{FUNC_DISARM,   8'd7,   32'h0000_0000, 1'b0, 1'b0, MODE_IDLE,      8'h00},
        '{FUNC_BOUNDARY, 8'd0,   32'h0000_0000, 1'b1, 1'b1, MODE_IDLE,      8'h00}
    };

    initial begin
        due_t                      pin;
        due_t                      loose;
        logic [FUNC_W-1:0]         f;
        logic [STEM_IDX_W-1:0]     stem;
        logic [SETTING_PORT_W-1:0] word;
        int                        real_items;
        int                        pick;
        int                        n;

        loose.r             = '0;
        loose.pinned        = 1'b0;
        loose.acc           = 1'b0;
        loose.md            = MODE_IDLE;
        loose.mask          = '0;
        req_ch.valid        <= 1'b0;
        req_ch.func         <= '0;
        req_ch.stem_index   <= '0;
        req_ch.stem_setting <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Walk the directed table
        foreach (script[i]) begin
            pin        = loose;
            pin.pinned = script[i].pinned;
            pin.acc    = script[i].acc;
            pin.md     = script[i].md;
            pin.mask   = script[i].mask;
            offer(script[i].f, script[i].stem, script[i].word, pin);
        end

        // Random part: mostly request batches closed by a boundary, with
        // the request mix steered by the mode so the recorder keeps cycling.
        // Long batches overrun the ring and exercise the full refusal.
        real_items = 0;
        while (real_items < RAND_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 20)
                                                : $urandom_range(0, 6);
                repeat (n) begin
                    pick = $urandom_range(0, 99);
                    stem = ($urandom_range(0, 6) == 0)
                           ? 8'($urandom_range(0, 255))
                           : 8'($urandom_range(0, STEM_COUNT_DEF - 1));
                    word = $urandom;
                    if (rec_mode == MODE_IDLE) begin
                        if (pick < 35)      f = FUNC_ARM;
                        else if (pick < 55) f = FUNC_DISARM;
                        else if (pick < 80) f = FUNC_START;
                        else if (pick < 92) f = FUNC_STOP;
                        else f = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
                    end else begin
                        if (pick < 45)      f = FUNC_STOP;
                        else if (pick < 65) f = FUNC_START;
                        else if (pick < 75) f = FUNC_ARM;
                        else if (pick < 85) f = FUNC_DISARM;
                        else f = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
                    end
                    offer(f, stem, word, loose);
                    real_items++;
                end
                offer(FUNC_BOUNDARY, 8'($urandom_range(0, 255)), $urandom, loose);
                real_items++;
            end else begin
                // Noise: any code, any stem, boundaries at random places
                repeat ($urandom_range(1, 6)) begin
                    f = 3'($urandom_range(0, 7));
                    offer(f, 8'($urandom_range(0, 255)), $urandom, loose);
                    real_items++;
                end
            end
        end
        req_ch.valid <= 1'b0;

        // Drain outstanding statuses, then let the block settle
        while (status_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        if (mismatches == 0)
            $display("** recorder_command_sequencer_top: PASSED **");
        else
            $display("** recorder_command_sequencer_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Status side: stall in random styles, each held for a random stretch,
    // and twice hold ready low for a long stretch so the output
    // register fills and the request channel backs up.
    // ------------------------------------------------------------------
    initial begin
        int style;
        int left;
        int age;
        int hold;

        style = 0;
        left  = 0;
        age   = 0;
        hold  = 0;
        res_ch.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            age++;
            if (age == 1500 || age == 9000)
                hold = 400;
            if (hold > 0) begin
                hold--;
                res_ch.ready <= 1'b0;
            end else begin
                if (left == 0) begin
                    style = $urandom_range(0, 3);
                    left  = $urandom_range(8, 64);
                end
                left--;
                case (style)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: res_ch.ready <= age[1];
                endcase
            end
        end
    end

    // Compare every status transfer against the oldest expectation
    always @(posedge clk) begin : status_mon
        result_t got;
        due_t    e;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got.accepted              = res_ch.accepted;
            got.mode                  = res_ch.mode;
            got.armed_mask            = res_ch.armed_mask;
            got.start_count           = res_ch.start_count;
            got.stop_count            = res_ch.stop_count;
            got.arm_count             = res_ch.arm_count;
            got.disarm_count          = res_ch.disarm_count;
            got.refused_setting_count = res_ch.refused_setting_count;
            got.refused_mode_count    = res_ch.refused_mode_count;
            got.boundary_count        = res_ch.boundary_count;
            got.transition_total      = res_ch.transition_total;
            if (status_due.size() == 0) begin
                flag("unexpected status transfer", got.boundary_count, 0);
            end else begin
                e = status_due.pop_front();
                check_status(got, e);
            end
        end
    end

    // Watchdog: the slowest legal run finishes far below this
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** recorder_command_sequencer_top: FAILED **");
            $finish;
        end
    end

endmodule
